// ===== src/fixed_slot_key_value_store_top_assert.svh =====
// Assertion macros for the store's checker file.
`ifndef FIXED_SLOT_KEY_VALUE_STORE_TOP_ASSERT_SVH
`define FIXED_SLOT_KEY_VALUE_STORE_TOP_ASSERT_SVH

// Concurrent check sampled on the clock, off while reset is high.
`define FKV_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Implication form: antecedent, then consequent.
`define FKV_ASSERT_IMP(lbl, ante, cons, msg) \
   `FKV_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// ===== src/fkv_pkg.sv =====
// Package: item types, status and opcode codes, CRC helpers for the store.
package fkv_pkg;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [63:0] key_bytes;
      logic [7:0]  key_length;
      logic [63:0] value_in;
      logic [7:0]  value_length_in;
      logic [7:0]  capacity;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        found;
      logic [63:0] value_out;
      logic [3:0]  length_out;
      logic [3:0]  slot_out;
      logic [4:0]  count_out;
   } rsp_type;

   // One stored record.
   typedef struct packed {
      logic [63:0] key;
      logic [3:0]  klen;
      logic [63:0] value;
      logic [3:0]  vlen;
      logic [31:0] crc;
   } slot_rec_type;

   // Priority chain passed from cell to cell.
   typedef struct packed {
      logic        hit;
      logic        free;
      logic [63:0] value;
      logic [3:0]  vlen;
      logic [31:0] crc;
   } chain_type;

   localparam logic [1:0] OP_SET    = 2'd0;
   localparam logic [1:0] OP_GET    = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;
   localparam logic [1:0] OP_EXISTS = 2'd3;

   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_INVALID     = 3'd1;
   localparam logic [2:0] ST_NO_RESOURCE = 3'd2;
   localparam logic [2:0] ST_IO_ERROR    = 3'd3;
   localparam logic [2:0] ST_BUF_SMALL   = 3'd4;

   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

   // Keep the low n bytes of a word.
   function automatic logic [63:0] byte_mask(input logic [3:0] n);
      logic [63:0] m;
      m = '0;
      for (int i = 0; i < 8; i++) begin
         m[i*8 +: 8] = (4'(i) < n) ? 8'hFF : 8'h00;
      end
      return m;
   endfunction

   // Fold one byte into a reflected CRC-32.
   function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      end
      return r;
   endfunction

endpackage

// ===== src/fkv_cell.sv =====
// One slot of the table: stored record, key compare and priority chain link.
module fkv_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 lookup,
   input  logic [63:0]          key,
   input  logic [3:0]           klen,
   input  logic                 wr_en,
   input  logic                 clr_en,
   input  fkv_pkg::slot_rec_type wr_rec,
   input  fkv_pkg::chain_type   chain_in,
   output fkv_pkg::chain_type   chain_out,
   output logic                 hit_sel,
   output logic                 free_sel
);
   import fkv_pkg::*;

   logic         used_ff, used_in;
   slot_rec_type rec_ff;
   logic         match_ff, match_in;

   // Compare the stored key against the request.
   assign match_in = used_ff && (rec_ff.klen == klen) && (rec_ff.key == key);

   always_comb begin
      used_in = used_ff;
      if (wr_en) begin
         used_in = 1'b1;
      end else if (clr_en) begin
         used_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         used_ff <= used_in;
         if (lookup) begin
            match_ff <= match_in;
         end
      end
   end

   // Hold the record; no reset needed.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         rec_ff <= wr_rec;
      end
   end

   // First hit and first free slot win along the chain.
   assign hit_sel  = match_ff && !chain_in.hit;
   assign free_sel = !used_ff && !chain_in.free;

   always_comb begin
      chain_out      = chain_in;
      chain_out.hit  = chain_in.hit | match_ff;
      chain_out.free = chain_in.free | !used_ff;
      if (hit_sel) begin
         chain_out.value = rec_ff.value;
         chain_out.vlen  = rec_ff.vlen;
         chain_out.crc   = rec_ff.crc;
      end
   end

endmodule

// ===== src/fkv_crc.sv =====
// Byte-serial CRC-32 unit: one value byte per cycle.
module fkv_crc (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] data,
   input  logic [3:0]  len,
   output logic        done,
   output logic [31:0] crc
);
   import fkv_pkg::*;

   logic        busy_ff, busy_in;
   logic [31:0] crc_ff, crc_in;
   logic [63:0] data_ff, data_in;
   logic [3:0]  cnt_ff, cnt_in;

   assign done = busy_ff && (cnt_ff == 4'd0);
   assign crc  = ~crc_ff;

   always_comb begin
      busy_in = busy_ff;
      crc_in  = crc_ff;
      data_in = data_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         crc_in  = CRC_INIT;
         data_in = data;
         cnt_in  = len;
      end else if (busy_ff) begin
         if (cnt_ff == 4'd0) begin
            busy_in = 1'b0;
         end else begin
            // advance one byte
            crc_in  = crc_byte(crc_ff, data_ff[7:0]);
            data_in = data_ff >> 8;
            cnt_in  = cnt_ff - 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      crc_ff  <= crc_in;
      data_ff <= data_in;
      cnt_ff  <= cnt_in;
   end

endmodule

// ===== src/fixed_slot_key_value_store_top.sv =====
// Top level of the fixed-slot key/value store with value CRC-32.
//
// Request channel (req_*): one set, get, delete or exists item per handshake.
// Response channel (rsp_*): exactly one result item per request, in order.
// Config channel (csr_*): one bit, crc_enable, always ready; write it only
// while the store is idle.
// Timing: an item is taken only when the store is idle. Each item goes
// through match, pick and finish steps; with CRC enabled, a set that has
// a slot to write and a get that hits add a byte-serial CRC pass over the
// value between pick and finish. The finish step loads the result register,
// and the next item can be taken once the store is back in idle.
// The slots form a row of cells; each cell compares its key in parallel and
// passes first-hit and first-free flags plus hit data to its neighbor.
// Reset empties every slot, clears the count and sets crc_enable to 1.
// A stalled response holds in its output register; the next item is accepted
// meanwhile and its finish step waits until the register frees.
module fixed_slot_key_value_store_top #(
   parameter int RECORDS     = 16,
   parameter int KEY_BYTES   = 8,
   parameter int VALUE_BYTES = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  fkv_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output fkv_pkg::rsp_type rsp_payload,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_wdata
);
   import fkv_pkg::*;

   localparam int IW = (RECORDS > 1) ? $clog2(RECORDS) : 1;
   localparam int CW = $clog2(RECORDS + 1);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_MATCH = 5'b00010,
      S_PICK  = 5'b00100,
      S_CRC   = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic        crc_en_ff;
   req_type     req_ff;
   logic [63:0] key_ff, val_ff;
   logic [3:0]  klen_ff, vlen_ff;
   logic        invalid;

   logic          hit_ff, fresh_ff;
   logic [IW-1:0] idx_ff, idx_in;
   logic [63:0]   sval_ff;
   logic [3:0]    svlen_ff;
   logic [31:0]   scrc_ff;
   logic [31:0]   crc_res_ff;
   logic [CW-1:0] count_ff, count_in;

   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff;

   logic        crc_start, crc_done;
   logic [63:0] crc_data;
   logic [3:0]  crc_len;
   logic [31:0] crc_val;

   chain_type    chain [RECORDS+1];
   logic [RECORDS-1:0] hit_sel, free_sel, wr_vec, clr_vec;
   logic [IW-1:0] hit_idx, free_idx;
   slot_rec_type wr_rec;
   logic         fire, do_write, do_clear;

   assign req_ready   = (state_ff == S_IDLE);
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Config register.
   always_ff @(posedge clock) begin
      if (reset) begin
         crc_en_ff <= 1'b1;
      end else if (csr_valid) begin
         crc_en_ff <= csr_wdata;
      end
   end

   // Capture the request with key and value trimmed to their lengths.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff  <= req_payload;
         klen_ff <= req_payload.key_length[3:0];
         vlen_ff <= req_payload.value_length_in[3:0];
         key_ff  <= req_payload.key_bytes & byte_mask(req_payload.key_length[3:0]);
         val_ff  <= req_payload.value_in & byte_mask(req_payload.value_length_in[3:0]);
      end
   end

   assign invalid = (req_ff.key_length == 8'd0) ||
                    (req_ff.key_length > 8'(KEY_BYTES)) ||
                    ((req_ff.opcode == OP_SET) &&
                     (req_ff.value_length_in > 8'(VALUE_BYTES)));

   // Row of slot cells.
   assign chain[0] = '0;
   genvar g;
   generate
      for (g = 0; g < RECORDS; g++) begin : g_cell
         fkv_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .lookup    (state_ff == S_MATCH),
            .key       (key_ff),
            .klen      (klen_ff),
            .wr_en     (wr_vec[g]),
            .clr_en    (clr_vec[g]),
            .wr_rec    (wr_rec),
            .chain_in  (chain[g]),
            .chain_out (chain[g+1]),
            .hit_sel   (hit_sel[g]),
            .free_sel  (free_sel[g])
         );
         assign wr_vec[g]  = do_write && (idx_ff == IW'(g));
         assign clr_vec[g] = do_clear && (idx_ff == IW'(g));
      end
   endgenerate

   // Encode the one-hot picks.
   always_comb begin
      hit_idx  = '0;
      free_idx = '0;
      for (int i = 0; i < RECORDS; i++) begin
         if (hit_sel[i]) begin
            hit_idx = hit_idx | IW'(i);
         end
         if (free_sel[i]) begin
            free_idx = free_idx | IW'(i);
         end
      end
   end

   assign idx_in = chain[RECORDS].hit ? hit_idx : free_idx;

   // Start the CRC pass on the new value (set) or the stored one (get).
   assign crc_start = (state_ff == S_PICK) && !invalid && crc_en_ff &&
                      (((req_ff.opcode == OP_SET) &&
                        (chain[RECORDS].hit || chain[RECORDS].free)) ||
                       ((req_ff.opcode == OP_GET) && chain[RECORDS].hit));
   assign crc_data  = (req_ff.opcode == OP_SET) ? val_ff : chain[RECORDS].value;
   assign crc_len   = (req_ff.opcode == OP_SET) ? vlen_ff : chain[RECORDS].vlen;

   fkv_crc u_crc (
      .clock (clock),
      .reset (reset),
      .start (crc_start),
      .data  (crc_data),
      .len   (crc_len),
      .done  (crc_done),
      .crc   (crc_val)
   );

   // Hold the picked slot and its contents.
   always_ff @(posedge clock) begin
      if (state_ff == S_PICK) begin
         hit_ff   <= chain[RECORDS].hit;
         fresh_ff <= !chain[RECORDS].hit && chain[RECORDS].free;
         idx_ff   <= idx_in;
         sval_ff  <= chain[RECORDS].value;
         svlen_ff <= chain[RECORDS].vlen;
         scrc_ff  <= chain[RECORDS].crc;
      end
      if (crc_done) begin
         crc_res_ff <= crc_val;
      end
   end

   assign fire = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_MATCH;
            end
         end
         S_MATCH: state_in = S_PICK;
         S_PICK:  state_in = crc_start ? S_CRC : S_DONE;
         S_CRC: begin
            if (crc_done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (fire) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Build the result and the table update.
   always_comb begin
      rsp_in        = '0;
      count_in      = count_ff;
      do_write      = 1'b0;
      do_clear      = 1'b0;
      wr_rec.key    = key_ff;
      wr_rec.klen   = klen_ff;
      wr_rec.value  = val_ff;
      wr_rec.vlen   = vlen_ff;
      wr_rec.crc    = crc_en_ff ? crc_res_ff : 32'd0;
      rsp_in.status = ST_OK;
      if (invalid) begin
         rsp_in.status = ST_INVALID;
      end else begin
         rsp_in.found = hit_ff;
         unique case (req_ff.opcode)
            OP_SET: begin
               if (!hit_ff && !fresh_ff) begin
                  rsp_in.status = ST_NO_RESOURCE;
               end else begin
                  do_write        = fire;
                  rsp_in.slot_out = 4'(idx_ff);
                  if (fresh_ff && (count_ff < CW'(RECORDS))) begin
                     count_in = count_ff + CW'(1);
                  end
               end
            end
            OP_GET: begin
               if (!hit_ff) begin
                  rsp_in.status = ST_NO_RESOURCE;
               end else begin
                  rsp_in.slot_out = 4'(idx_ff);
                  if (crc_en_ff && (scrc_ff != crc_res_ff)) begin
                     rsp_in.status = ST_IO_ERROR;
                  end else begin
                     rsp_in.length_out = svlen_ff;
                     if ({4'd0, svlen_ff} > req_ff.capacity) begin
                        rsp_in.status = ST_BUF_SMALL;
                     end else begin
                        rsp_in.value_out = sval_ff;
                     end
                  end
               end
            end
            OP_DELETE: begin
               if (!hit_ff) begin
                  rsp_in.status = ST_NO_RESOURCE;
               end else begin
                  do_clear        = fire;
                  rsp_in.slot_out = 4'(idx_ff);
                  if (count_ff != '0) begin
                     count_in = count_ff - CW'(1);
                  end
               end
            end
            OP_EXISTS: begin
               if (hit_ff) begin
                  rsp_in.slot_out = 4'(idx_ff);
               end
            end
            default: rsp_in.status = ST_OK;
         endcase
      end
      rsp_in.count_out = 5'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (fire) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ===== src/fkv_checker.sv =====
// Port checker for the key/value store, bound to the top level.
`include "fixed_slot_key_value_store_top_assert.svh"

module fkv_checker #(
   parameter int RECORDS = 16
) (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input fkv_pkg::rsp_type rsp_payload
);
   import fkv_pkg::*;

   // A stalled result holds.
   `FKV_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload), "rsp changed while stalled")

   // One item at a time.
   `FKV_ASSERT(a_one_item, req_valid && req_ready |=> !req_ready, "req taken while busy")

   // Count never passes the table size.
   `FKV_ASSERT_IMP(a_count, rsp_valid, 32'(rsp_payload.count_out) <= 32'(RECORDS) || RECORDS > 31, "count above table size")

   // Bad arguments report nothing found.
   `FKV_ASSERT_IMP(a_invalid, rsp_valid && rsp_payload.status == ST_INVALID, !rsp_payload.found && rsp_payload.value_out == 64'd0 && rsp_payload.slot_out == 4'd0, "invalid_arg with data")

   // Value data only with ok status.
   `FKV_ASSERT_IMP(a_value_ok, rsp_valid && rsp_payload.value_out != 64'd0, rsp_payload.status == ST_OK && rsp_payload.found, "value on failed item")

endmodule

bind fixed_slot_key_value_store_top fkv_checker #(.RECORDS(RECORDS)) u_fkv_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

// ===== verif/fkv_scoreboard.sv =====
// Checker for the key/value store: watches the channels, predicts, compares.
`timescale 1ns / 100ps

module fkv_scoreboard (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  fkv_pkg::req_type req_payload,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  fkv_pkg::rsp_type rsp_payload,
   input  logic             csr_valid,
   input  logic             csr_ready,
   input  logic             csr_wdata,
   output int               fail_count,
   output int               pending_count
);
   import fkv_pkg::*;

   localparam int NSLOT = 16;
   localparam int KMAX  = 8;
   localparam int VMAX  = 8;

   logic        crc_on;
   logic        used_q [NSLOT];
   logic [63:0] key_q  [NSLOT];
   logic [3:0]  klen_q [NSLOT];
   logic [63:0] val_q  [NSLOT];
   logic [3:0]  vlen_q [NSLOT];
   logic [31:0] crc_q  [NSLOT];
   logic [4:0]  total_q;
   rsp_type     expected_rsps [$];

   assign pending_count = expected_rsps.size();

   function automatic logic [63:0] low_bytes(input int n);
      return (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
   endfunction

   function automatic logic [31:0] value_crc32(input logic [63:0] v, input int n);
      logic [31:0] c;
      c = 32'hFFFF_FFFF;
      for (int i = 0; i < n && i < 8; i++) begin
         c ^= {24'd0, v[8*i +: 8]};
         for (int b = 0; b < 8; b++) c = c[0] ? ((c >> 1) ^ 32'hEDB8_8320) : (c >> 1);
      end
      return ~c;
   endfunction

   // Apply one request to the shadow table and return its result.
   function automatic rsp_type apply_request(input req_type r);
      rsp_type o;
      int      klen, vlen, idx;
      logic    hit, fresh;
      logic [63:0] k, v;
      o = '0;
      klen = int'(r.key_length);
      vlen = int'(r.value_length_in);
      hit = 1'b0;
      fresh = 1'b0;
      idx = 0;
      if (klen == 0 || klen > KMAX || (r.opcode == OP_SET && vlen > VMAX)) begin
         o.status = ST_INVALID;
      end else begin
         k = r.key_bytes & low_bytes(klen);
         for (int i = 0; i < NSLOT; i++)
            if (!hit && used_q[i] && int'(klen_q[i]) == klen && key_q[i] == k) begin
               hit = 1'b1;
               idx = i;
            end
         o.found = hit;
         if (r.opcode == OP_SET) begin
            if (!hit)
               for (int i = NSLOT - 1; i >= 0; i--)
                  if (!used_q[i]) begin
                     idx = i;
                     fresh = 1'b1;
                  end
            if (!hit && !fresh) begin
               o.status = ST_NO_RESOURCE;
            end else begin
               v = r.value_in & low_bytes(vlen);
               used_q[idx] = 1'b1;
               key_q[idx] = k;
               klen_q[idx] = 4'(klen);
               val_q[idx] = v;
               vlen_q[idx] = 4'(vlen);
               crc_q[idx] = crc_on ? value_crc32(v, vlen) : 32'd0;
               if (fresh && total_q < NSLOT) total_q++;
               o.slot_out = 4'(idx);
            end
         end else if (!hit) begin
            if (r.opcode != OP_EXISTS) o.status = ST_NO_RESOURCE;
         end else begin
            o.slot_out = 4'(idx);
            if (r.opcode == OP_GET) begin
               if (crc_on && crc_q[idx] != value_crc32(val_q[idx], int'(vlen_q[idx]))) begin
                  o.status = ST_IO_ERROR;
               end else begin
                  o.length_out = vlen_q[idx];
                  if ({4'd0, vlen_q[idx]} > r.capacity) o.status = ST_BUF_SMALL;
                  else o.value_out = val_q[idx] & low_bytes(int'(vlen_q[idx]));
               end
            end else if (r.opcode == OP_DELETE) begin
               used_q[idx] = 1'b0;
               if (total_q > 0) total_q--;
            end
         end
      end
      o.count_out = total_q;
      return o;
   endfunction

   // Predict on accepted requests, compare on accepted results.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         crc_on <= 1'b1;
         total_q = '0;
         for (int i = 0; i < NSLOT; i++) used_q[i] = 1'b0;
         expected_rsps.delete();
         fail_count <= 0;
      end else begin
         if (csr_valid && csr_ready) crc_on <= csr_wdata;
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10) $display("unexpected result item %p", rsp_payload);
            end else begin
               want = expected_rsps.pop_front();
               if (want !== rsp_payload) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display("mismatch: expected %p actual %p", want, rsp_payload);
               end
            end
         end
         if (req_valid && req_ready) expected_rsps.push_back(apply_request(req_payload));
      end
   end
endmodule

// ===== verif/tb_fixed_slot_key_value_store_top.sv =====
// Testbench top: stimulus for the key/value store and the final verdict.
`timescale 1ns / 100ps

module tb_fixed_slot_key_value_store_top;
   import fkv_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 0;
   rsp_type rsp_payload;
   logic    csr_valid = 0;
   logic    csr_ready;
   logic    csr_wdata = 0;
   int      fail_count;
   int      pending_count;
   int      cycle_count = 0;
   logic [63:0] key_pool [8];

   always #10 clock = ~clock;

   fixed_slot_key_value_store_top i_dut (
      .clock, .reset, .req_valid, .req_ready, .req_payload,
      .rsp_valid, .rsp_ready, .rsp_payload, .csr_valid, .csr_ready, .csr_wdata
   );

   fkv_scoreboard i_checker (
      .clock, .reset, .req_valid, .req_ready, .req_payload,
      .rsp_valid, .rsp_ready, .rsp_payload, .csr_valid, .csr_ready, .csr_wdata,
      .fail_count, .pending_count
   );

   // Count cycles and stop a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Stall the result side at random, with calm stretches.
   initial begin
      int wait_cycles;
      forever begin
         @(negedge clock);
         wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
         rsp_ready <= 0;
         repeat (wait_cycles) @(negedge clock);
         rsp_ready <= 1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   // Drive one item; valid stays high into the next item when there is no gap.
   task automatic send_item(input req_type r, input int gap);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_payload <= r;
      req_valid <= 1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic drain_all();
      req_valid <= 0;
      while (pending_count != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_crc_enable(input logic bit_value);
      drain_all();
      csr_wdata <= bit_value;
      csr_valid <= 1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   function automatic req_type build_item(input logic [1:0] op, input logic [63:0] key,
                                          input int klen, input logic [63:0] val,
                                          input int vlen, input int cap);
      req_type r;
      r.opcode = op;
      r.key_bytes = key;
      r.key_length = 8'(klen);
      r.value_in = val;
      r.value_length_in = 8'(vlen);
      r.capacity = 8'(cap);
      return r;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Draw a mostly well-formed request over a small key pool.
   function automatic req_type random_item();
      req_type r;
      int      pick;
      r = build_item(2'($urandom_range(0, 3)), key_pool[3'($urandom_range(0, 7))],
                     $urandom_range(1, 8), rand64(), $urandom_range(0, 8),
                     $urandom_range(0, 10));
      if (r.opcode != OP_SET && $urandom_range(0, 1)) r.opcode = OP_SET;
      pick = $urandom_range(0, 19);
      if (pick == 0) r.key_length = 8'($urandom_range(0, 255));
      if (pick == 1) r.value_length_in = 8'($urandom_range(0, 255));
      if (pick == 2) r.capacity = 8'($urandom_range(0, 255));
      if (pick == 3) r.key_bytes = rand64();
      return r;
   endfunction

   initial begin
      req_type r;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: limits, every operation, each corner.
      send_item(build_item(OP_SET, '1, 0, '1, 8, 0), 0);
      send_item(build_item(OP_GET, '1, 9, 0, 0, 8), 0);
      send_item(build_item(OP_SET, '1, 8, '1, 9, 0), 0);
      send_item(build_item(OP_SET, '1, 255, '1, 255, 255), 0);
      send_item(build_item(OP_SET, 64'h1122, 2, '1, 8, 0), 0);
      send_item(build_item(OP_GET, 64'hFF1122, 2, 0, 0, 8), 1);
      send_item(build_item(OP_GET, 64'h1122, 2, 0, 0, 7), 0);
      send_item(build_item(OP_SET, 64'h1122, 2, 64'h55, 0, 0), 0);
      send_item(build_item(OP_GET, 64'h1122, 2, 0, 0, 0), 0);
      send_item(build_item(OP_EXISTS, 64'h1122, 2, 0, 0, 0), 0);
      send_item(build_item(OP_EXISTS, 64'h1123, 2, 0, 0, 0), 0);
      send_item(build_item(OP_DELETE, 64'h1122, 2, 0, 0, 0), 0);
      send_item(build_item(OP_DELETE, 64'h1122, 2, 0, 0, 0), 0);
      send_item(build_item(OP_GET, 64'h1122, 2, 0, 0, 8), 0);
      // Fill the table, then one more key.
      for (int i = 0; i < 17; i++)
         send_item(build_item(OP_SET, 64'(i), 1, rand64(), 3, 0), 0);
      // Record written without CRC, read back with CRC on.
      write_crc_enable(0);
      send_item(build_item(OP_SET, 64'd2, 1, 64'hABCD, 2, 0), 0);
      write_crc_enable(1);
      send_item(build_item(OP_GET, 64'd2, 1, 0, 0, 8), 0);
      for (int i = 0; i < 16; i++)
         send_item(build_item(OP_DELETE, 64'(i), 1, 0, 0, 0), 0);

      // Random phases with both register settings.
      for (int phase = 0; phase < 8; phase++) begin
         for (int i = 0; i < 8; i++) key_pool[i] = rand64();
         write_crc_enable(phase[0]);
         for (int n = 0; n < 250; n++) begin
            r = random_item();
            send_item(r, ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 8));
            if (n == 125 && phase == 3) drain_all();
         end
      end

      drain_all();
      if (fail_count == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end
endmodule
